>>> sv/note_name_parser_assert.svh
// Assertion macros shared by the note name parser verification files.
// Each macro expands to one labeled concurrent assertion on clk_i with
// the active-low reset rst_ni disabling the check.
`ifndef NOTE_NAME_PARSER_ASSERT_SVH
`define NOTE_NAME_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NNP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("note name parser check failed");

// The consequent must hold in the cycle after the antecedent.
`define NNP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("note name parser check failed");

`endif

>>> sv/nnp_pkg.sv
`default_nettype none

package nnp_pkg;

  // Number of result slots in the output event queue.
  localparam int unsigned QueueDepth = 2;

  // Characters the parser recognizes.
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_REST  = 8'h2D;
  localparam logic [7:0] CHAR_SHARP = 8'h23;
  localparam logic [7:0] CHAR_FLAT  = 8'h62;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_G     = 8'h47;
  localparam logic [7:0] CHAR_OCT_LO = 8'h35;
  localparam logic [7:0] CHAR_OCT_HI = 8'h37;

  // Pitch arithmetic constants.
  localparam logic [5:0] SEMIS_PER_OCTAVE = 6'd12;
  localparam logic [4:0] WHITES_PER_OCTAVE = 5'd7;
  localparam logic [5:0] PITCH_MAX = 6'd35;

  typedef enum logic [1:0] {
    KIND_NOTE  = 2'd0,
    KIND_REST  = 2'd1,
    KIND_END   = 2'd2,
    KIND_ERROR = 2'd3
  } event_kind_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_OCTAVE = 2'd1,
    PH_ACCID  = 2'd2,
    PH_HALT   = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] character;
    logic       restart;
  } nnp_in_t;

  typedef struct packed {
    event_kind_e event_kind;
    logic [5:0]  pitch_index;
    logic [4:0]  white_index;
    logic [11:0] frequency_hz;
    logic        last;
  } nnp_out_t;

  // Events produced by one character, handed from the parser to the queue.
  typedef struct packed {
    logic [1:0] count;
    nnp_out_t   ev0;
    nnp_out_t   ev1;
  } nnp_step_t;

  // Semitone of a note letter above C, letters A through G.
  function automatic logic [3:0] letter_semitone(input logic [2:0] letter);
    logic [3:0] semi;
    unique case (letter)
      3'd0:    semi = 4'd9;
      3'd1:    semi = 4'd11;
      3'd2:    semi = 4'd0;
      3'd3:    semi = 4'd2;
      3'd4:    semi = 4'd4;
      3'd5:    semi = 4'd5;
      3'd6:    semi = 4'd7;
      default: semi = 4'd0;
    endcase
    return semi;
  endfunction

  // Equal-tempered tone frequency in Hz for semitone index 0 (C5) to 35 (B7).
  function automatic logic [11:0] tone_hz(input logic [5:0] pitch);
    logic [11:0] hz;
    unique case (pitch)
      6'd0:  hz = 12'd523;   6'd1:  hz = 12'd554;   6'd2:  hz = 12'd587;
      6'd3:  hz = 12'd622;   6'd4:  hz = 12'd659;   6'd5:  hz = 12'd698;
      6'd6:  hz = 12'd740;   6'd7:  hz = 12'd784;   6'd8:  hz = 12'd831;
      6'd9:  hz = 12'd880;   6'd10: hz = 12'd932;   6'd11: hz = 12'd988;
      6'd12: hz = 12'd1047;  6'd13: hz = 12'd1109;  6'd14: hz = 12'd1175;
      6'd15: hz = 12'd1245;  6'd16: hz = 12'd1319;  6'd17: hz = 12'd1397;
      6'd18: hz = 12'd1480;  6'd19: hz = 12'd1568;  6'd20: hz = 12'd1661;
      6'd21: hz = 12'd1760;  6'd22: hz = 12'd1865;  6'd23: hz = 12'd1976;
      6'd24: hz = 12'd2093;  6'd25: hz = 12'd2217;  6'd26: hz = 12'd2349;
      6'd27: hz = 12'd2489;  6'd28: hz = 12'd2637;  6'd29: hz = 12'd2794;
      6'd30: hz = 12'd2960;  6'd31: hz = 12'd3136;  6'd32: hz = 12'd3322;
      6'd33: hz = 12'd3520;  6'd34: hz = 12'd3729;  6'd35: hz = 12'd3951;
      default: hz = 12'd0;
    endcase
    return hz;
  endfunction

  // Builds one event. Only an in-range note keeps its indices and frequency.
  function automatic nnp_out_t make_event(input event_kind_e kind,
                                          input logic [5:0] pitch,
                                          input logic [4:0] white);
    nnp_out_t ev;
    ev.event_kind = kind;
    ev.last       = 1'b0;
    if (kind == KIND_NOTE && pitch <= PITCH_MAX) begin
      ev.pitch_index  = pitch;
      ev.white_index  = white;
      ev.frequency_hz = tone_hz(pitch);
    end else begin
      ev.pitch_index  = '0;
      ev.white_index  = '0;
      ev.frequency_hz = '0;
    end
    return ev;
  endfunction

endpackage

`default_nettype wire

>>> sv/nnp_parse.sv
`default_nettype none

module nnp_parse import nnp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  wire nnp_in_t   item_i,
  output nnp_step_t      result_o
);

  phase_e     phase_q, phase_d;
  logic [5:0] sem_q, sem_d;
  logic [4:0] white_q, white_d;

  phase_e     ph;
  logic [5:0] sem;
  logic [4:0] white;
  logic [7:0] c;

  // Token start decode, shared by the idle phase and the end of a note.
  logic       ts_emit;
  logic       ts_letter;
  logic       ts_halt;
  event_kind_e ts_kind;
  logic [5:0] ts_sem;
  logic [2:0] letter;

  // Octave arithmetic.
  logic [1:0] oct;
  logic [3:0] base_semi;
  logic [5:0] oct_sem;
  logic [4:0] oct_white;
  logic [6:0] sharp_p;

  logic [1:0] n;
  nnp_out_t   ev_a, ev_b;

  assign c = item_i.character;

  // Restart clears the parser before the character is looked at.
  always_comb begin
    if (item_i.restart) begin
      ph    = PH_IDLE;
      sem   = '0;
      white = '0;
    end else begin
      ph    = phase_q;
      sem   = sem_q;
      white = white_q;
    end
  end

  // Classify a character as the first of a token.
  always_comb begin
    letter    = 3'(c - CHAR_A);
    ts_sem    = {2'b00, letter_semitone(letter)};
    ts_emit   = 1'b0;
    ts_letter = 1'b0;
    ts_halt   = 1'b0;
    ts_kind   = KIND_ERROR;
    if (c == CHAR_SPACE) begin
      ts_emit = 1'b0;
    end else if (c == CHAR_REST) begin
      ts_emit = 1'b1;
      ts_kind = KIND_REST;
    end else if (c >= CHAR_A && c <= CHAR_G) begin
      ts_letter = 1'b1;
    end else begin
      ts_emit = 1'b1;
      ts_halt = 1'b1;
      ts_kind = (c == CHAR_NUL) ? KIND_END : KIND_ERROR;
    end
  end

  // Semitone and white-key index once the octave digit is known.
  always_comb begin
    oct       = 2'(c - CHAR_OCT_LO);
    base_semi = sem[3:0];
    oct_white = 5'(WHITES_PER_OCTAVE * {3'b000, oct})
              + 5'((5'({1'b0, base_semi}) + 5'd1) >> 1);
    oct_sem   = 6'({2'b00, base_semi}) + 6'(SEMIS_PER_OCTAVE * {4'b0000, oct});
    sharp_p   = {1'b0, sem} + 7'd1;
  end

  // Next state and the events this character causes.
  always_comb begin
    phase_d = ph;
    sem_d   = sem;
    white_d = white;
    n       = 2'd0;
    ev_a    = make_event(KIND_ERROR, '0, '0);
    ev_b    = make_event(KIND_ERROR, '0, '0);
    unique case (ph)
      PH_IDLE: begin
        if (ts_letter) begin
          sem_d   = ts_sem;
          white_d = '0;
          phase_d = PH_OCTAVE;
        end
        if (ts_halt) begin
          phase_d = PH_HALT;
        end
        if (ts_emit) begin
          n    = 2'd1;
          ev_a = make_event(ts_kind, '0, '0);
        end
      end
      PH_OCTAVE: begin
        if (c >= CHAR_OCT_LO && c <= CHAR_OCT_HI) begin
          white_d = oct_white;
          sem_d   = oct_sem;
          phase_d = PH_ACCID;
        end else begin
          phase_d = PH_HALT;
          n       = 2'd1;
          ev_a    = make_event(KIND_ERROR, '0, '0);
        end
      end
      PH_ACCID: begin
        phase_d = PH_IDLE;
        n       = 2'd1;
        if (c == CHAR_SHARP) begin
          if (sharp_p > 7'(PITCH_MAX)) begin
            phase_d = PH_HALT;
            ev_a    = make_event(KIND_ERROR, '0, '0);
          end else begin
            ev_a = make_event(KIND_NOTE, sharp_p[5:0], white);
          end
        end else if (c == CHAR_FLAT) begin
          if (sem == '0) begin
            ev_a = make_event(KIND_REST, '0, '0);
          end else begin
            ev_a = make_event(KIND_NOTE, sem - 6'd1, white);
          end
        end else begin
          // The pending note ends here and the character starts a new token.
          ev_a = make_event(KIND_NOTE, sem, white);
          if (ts_letter) begin
            sem_d   = ts_sem;
            white_d = '0;
            phase_d = PH_OCTAVE;
          end
          if (ts_halt) begin
            phase_d = PH_HALT;
          end
          if (ts_emit) begin
            n    = 2'd2;
            ev_b = make_event(ts_kind, '0, '0);
          end
        end
      end
      PH_HALT: begin
        phase_d = PH_HALT;
      end
      default: begin
        phase_d = PH_HALT;
      end
    endcase
  end

  // Mark the final event of this character.
  always_comb begin
    result_o.count    = n;
    result_o.ev0      = ev_a;
    result_o.ev0.last = (n == 2'd1);
    result_o.ev1      = ev_b;
    result_o.ev1.last = 1'b1;
  end

  // Parser state advances once per consumed character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      sem_q   <= '0;
      white_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      sem_q   <= sem_d;
      white_q <= white_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/nnp_evq.sv
`default_nettype none

module nnp_evq import nnp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire nnp_step_t  step_i,
  output logic [1:0]      free_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output nnp_out_t        out_item_o
);

  logic [1:0] cnt_q, cnt_d;
  nnp_out_t   slot_q [QueueDepth];
  nnp_out_t   slot_d [QueueDepth];
  logic       pop;
  logic [1:0] mid_cnt;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = slot_q[0];
  assign pop         = out_valid_o && !out_stall_i;
  assign mid_cnt     = cnt_q - {1'b0, pop};
  // Slots free this cycle, counting the one a completed transaction empties.
  assign free_o      = 2'(QueueDepth) - mid_cnt;

  // Shift out the delivered event, then append the new ones behind it.
  always_comb begin
    slot_d[0] = pop ? slot_q[1] : slot_q[0];
    slot_d[1] = slot_q[1];
    cnt_d     = mid_cnt;
    if (push_i && step_i.count != 2'd0) begin
      if (mid_cnt == 2'd0) begin
        slot_d[0] = step_i.ev0;
        slot_d[1] = step_i.ev1;
      end else begin
        slot_d[1] = step_i.ev0;
      end
      cnt_d = mid_cnt + step_i.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q[0] <= slot_d[0];
    slot_q[1] <= slot_d[1];
  end

endmodule

`default_nettype wire

>>> sv/note_name_parser.sv
// Note name parser: turns a tune's pitch string, one ASCII byte per input
// transaction, into note, rest, end and error events.
// Input channel: in_valid_i / in_stall_o with in_item_i carrying the
// character and a restart flag that clears the parser before that byte.
// Output channel: out_valid_o / out_stall_i with out_item_o carrying one
// event; last marks the final event caused by a character.
// Each byte is held in an input register, parsed there by short logic and
// its events written into a two-slot output queue. An event reaches the output
// port once its byte has left the input register and been written into the
// queue. One byte is taken per cycle while each byte yields at most one event
// and the output is not stalled; a byte that ends a note and starts a rest,
// end or error yields two events, which leave through the queue's single read
// port one after the other.
// Bytes that yield no event (spaces, letters, octave digits, bytes after an
// end or error) pass at one per cycle.
// Reset empties the input register and the queue and returns the parser to
// idle. A stall on the output holds the head event; once the queue cannot
// take the next byte's events, in_stall_o rises and the byte waits.
`default_nettype none

module note_name_parser import nnp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire nnp_in_t  in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output nnp_out_t      out_item_o
);

  logic      in_valid_q;
  nnp_in_t   in_q;
  logic      in_accept;
  logic      advance;
  logic [1:0] free;
  nnp_step_t step;

  // The held byte moves on when the queue has room for all its events.
  assign advance    = in_valid_q && (step.count <= free);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_accept || (in_valid_q && !advance);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_item_i;
    end
  end

  nnp_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_q),
    .result_o (step)
  );

  nnp_evq u_evq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (advance),
    .step_i      (step),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

>>> sv/nnp_checker.sv
`default_nettype none

`include "note_name_parser_assert.svh"

module nnp_checker import nnp_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire nnp_out_t out_item_o
);

  // A stalled event stays on the port unchanged.
  `NNP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))

  // A note carries a pitch within the table and a nonzero frequency.
  `NNP_ASSERT_NOW(a_note_range, out_valid_o && out_item_o.event_kind == KIND_NOTE, out_item_o.pitch_index <= PITCH_MAX && out_item_o.white_index <= 5'd20 && out_item_o.frequency_hz != 12'd0)

  // Any other event has its pitch fields cleared.
  `NNP_ASSERT_NOW(a_other_zero, out_valid_o && out_item_o.event_kind != KIND_NOTE, out_item_o.pitch_index == '0 && out_item_o.white_index == '0 && out_item_o.frequency_hz == '0)

  // An end or error event is always the final event of its character.
  `NNP_ASSERT_NOW(a_halt_last, out_valid_o && (out_item_o.event_kind == KIND_END || out_item_o.event_kind == KIND_ERROR), out_item_o.last)

endmodule

bind note_name_parser nnp_checker u_nnp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
